// ===== sv/tcadc_pkg.sv =====
package tcadc_pkg;

    localparam int SAMPLE_W       = 10;
    localparam int BYTE_W         = 8;
    localparam int SUM_W          = 16;
    localparam int DEF_WINDOW_LEN = 20;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic                sample_kept;
        logic                next_is_aux;
        logic [SAMPLE_W-1:0] main_reading;
        logic [BYTE_W-1:0]   main_reading_byte;
        logic [SAMPLE_W-1:0] aux_reading;
        logic [BYTE_W-1:0]   aux_reading_byte;
        logic [SUM_W-1:0]    window_sum;
        logic [SAMPLE_W-1:0] window_average;
    } out_item_t;

    // Snapshot of the state after one transaction, before the divide stage
    typedef struct packed {
        logic                sample_kept;
        logic                next_is_aux;
        logic [SAMPLE_W-1:0] main_reading;
        logic [SAMPLE_W-1:0] aux_reading;
        logic [SUM_W-1:0]    window_sum;
    } snap_t;

endpackage

// ===== sv/tcadc_if.sv =====
interface tcadc_in_if;
    import tcadc_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface tcadc_out_if;
    import tcadc_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

// ===== sv/two_channel_adc_moving_average.sv =====
// Two-channel converter sampler with a boxcar moving average on the main channel.
//
// samples: one 10-bit conversion per transaction, of the channel that the last
//   result reported in next_is_aux. The first conversion after each channel
//   switch is dropped (sample_kept = 0).
// results: exactly one result per sample, in order: the last readings of both
//   channels, their upper 8 bits, the window sum and the sum / WINDOW_LEN.
//
// From acceptance to result valid, a sample passes one register stage for the
// state update (ring write, running-sum add/subtract), one for the reciprocal
// multiply that forms the average. Throughput is one sample per cycle while
// the receiver takes results; the ring memory has one write and one prefetch
// read port, so the oldest entry is always ready for the next main-channel sample.
//
// Reset clears all control state and the ring (per-entry valid bits), so the
// ring reads as zero at once; no clearing pass is needed.
// When the receiver stalls, the output register holds its result and the
// first stage still takes one more sample; ready drops only when both are full.
module two_channel_adc_moving_average #(
    parameter int WINDOW_LEN = tcadc_pkg::DEF_WINDOW_LEN
) (
    input  logic        clk,
    input  logic        rst_n,
    tcadc_in_if.sink    samples,
    tcadc_out_if.source results
);
    import tcadc_pkg::*;

    localparam int PosW     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int DivShift = SUM_W + $clog2(WINDOW_LEN);
    localparam int MulW     = SUM_W + 1;
    localparam int ProdW    = SUM_W + MulW;
    localparam logic [MulW-1:0] DivMul =
        MulW'(((64'd1 << DivShift) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));
    localparam logic [PosW-1:0] LastPos = PosW'(WINDOW_LEN - 1);

    // Channel and ring state
    logic                  discard_reg, discard_next;
    logic                  aux_reg, aux_next;
    logic [PosW-1:0]       pos_reg, pos_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [SAMPLE_W-1:0]   last_main_reg, last_main_next;
    logic [SAMPLE_W-1:0]   last_aux_reg, last_aux_next;
    logic [WINDOW_LEN-1:0] valid_reg;
    logic                  rd_valid_reg, rd_valid_next;
    logic                  bypass_reg, bypass_next;
    logic [SAMPLE_W-1:0]   rd_data_reg;
    logic [SAMPLE_W-1:0]   ring_mem [WINDOW_LEN];

    // Pipeline
    logic                  s1_valid_reg;
    snap_t                 s1_reg;
    snap_t                 snap;
    logic                  out_valid_reg;
    out_item_t             out_reg;
    out_item_t             out_next;

    logic                  accept;
    logic                  take_main;
    logic                  wrap;
    logic [PosW-1:0]       pos_inc;
    logic [SAMPLE_W-1:0]   s;
    logic [SAMPLE_W-1:0]   oldest;
    logic                  out_stage_ready;
    logic                  s1_ready;
    logic [ProdW-1:0]      quot_prod;
    logic [ProdW-1:0]      quot_full;

    assign out_stage_ready = !out_valid_reg || results.ready;
    assign s1_ready        = !s1_valid_reg || out_stage_ready;
    assign samples.ready   = s1_ready;
    assign accept          = samples.valid && s1_ready;
    assign s               = samples.item.sample;

    assign take_main = accept && !discard_reg && !aux_reg;
    assign wrap      = (pos_reg == LastPos);
    assign pos_inc   = wrap ? '0 : pos_reg + PosW'(1);

    // Oldest entry at pos_reg: prefetched, or the last write when the ring is one deep
    assign oldest = bypass_reg ? last_main_reg : (rd_valid_reg ? rd_data_reg : '0);

    always_comb
    begin
        discard_next   = discard_reg;
        aux_next       = aux_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        last_main_next = last_main_reg;
        last_aux_next  = last_aux_reg;
        rd_valid_next  = rd_valid_reg;
        bypass_next    = bypass_reg;
        if (accept)
        begin
            if (discard_reg)
            begin
                discard_next = 1'b0;
            end
            else if (aux_reg)
            begin
                last_aux_next = s;
                aux_next      = 1'b0;
                discard_next  = 1'b1;
            end
            else
            begin
                last_main_next = s;
                sum_next       = sum_reg - SUM_W'(oldest) + SUM_W'(s);
                pos_next       = pos_inc;
                rd_valid_next  = valid_reg[pos_inc] && (pos_inc != pos_reg);
                bypass_next    = (pos_inc == pos_reg);
                if (wrap)
                begin
                    aux_next     = 1'b1;
                    discard_next = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        snap.sample_kept  = !discard_reg;
        snap.next_is_aux  = aux_next;
        snap.main_reading = last_main_next;
        snap.aux_reading  = last_aux_next;
        snap.window_sum   = sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            discard_reg   <= 1'b0;
            aux_reg       <= 1'b0;
            pos_reg       <= '0;
            sum_reg       <= '0;
            last_main_reg <= '0;
            last_aux_reg  <= '0;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            bypass_reg    <= 1'b0;
        end
        else
        begin
            discard_reg   <= discard_next;
            aux_reg       <= aux_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            last_main_reg <= last_main_next;
            last_aux_reg  <= last_aux_next;
            rd_valid_reg  <= rd_valid_next;
            bypass_reg    <= bypass_next;
            if (take_main)
            begin
                valid_reg[pos_reg] <= 1'b1;
            end
        end
    end

    // Ring memory: write the new sample, prefetch the entry it will replace next
    always_ff @(posedge clk)
    begin
        if (take_main)
        begin
            ring_mem[pos_reg] <= s;
            rd_data_reg       <= ring_mem[pos_inc];
        end
    end

    // Average by reciprocal multiply, exact for every 16-bit sum
    assign quot_prod = ProdW'(s1_reg.window_sum) * ProdW'(DivMul);
    assign quot_full = quot_prod >> DivShift;

    always_comb
    begin
        out_next.sample_kept       = s1_reg.sample_kept;
        out_next.next_is_aux       = s1_reg.next_is_aux;
        out_next.main_reading      = s1_reg.main_reading;
        out_next.main_reading_byte = s1_reg.main_reading[SAMPLE_W-1 -: BYTE_W];
        out_next.aux_reading       = s1_reg.aux_reading;
        out_next.aux_reading_byte  = s1_reg.aux_reading[SAMPLE_W-1 -: BYTE_W];
        out_next.window_sum        = s1_reg.window_sum;
        out_next.window_average    = quot_full[SAMPLE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= accept;
            end
            if (out_stage_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= snap;
        end
        if (out_stage_ready && s1_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.item  = out_reg;

endmodule

// ===== sv/tcadc_chk.sv =====
module tcadc_chk (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input tcadc_pkg::out_item_t out_item
);
    import tcadc_pkg::*;

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

    // A new result follows a sample transaction through the first-stage and output registers
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without a matching sample");

    // With the output empty, the first stage drains, so samples are always taken
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
    else $error("input stalled while output empty");

    // Byte readings track the 10-bit readings
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.main_reading_byte == out_item.main_reading[SAMPLE_W-1:2]
                   && out_item.aux_reading_byte == out_item.aux_reading[SAMPLE_W-1:2])
    else $error("byte reading mismatch");

endmodule

bind two_channel_adc_moving_average tcadc_chk u_tcadc_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_item  (results.item)
);
